/* hw/rtl/gsbp_pkg.sv */
// ----------------------------------------------------------------------------
// gsbp_pkg
// Shared types and constants of the single-bin Goertzel power detector.
// ----------------------------------------------------------------------------
package gsbp_pkg;

	// Field widths
	localparam int TAP_WIDTH = 32;
	localparam int COEF_W    = 16;
	localparam int SAMPLE_W  = 16;
	localparam int POWER_W   = 64;
	localparam int FRAC_W    = 14;
	localparam int ROUND_HALF = 1 << (FRAC_W - 1);

	// Shared multiplier: wide enough for a tap and for the low word of c*tap
	localparam int LO_W   = 32;
	localparam int MUL_W  = ((TAP_WIDTH > LO_W) ? TAP_WIDTH : LO_W) + 1;
	localparam int PROD_W = 2 * MUL_W;
	localparam int CA_W   = TAP_WIDTH + COEF_W;
	localparam int HI_W   = CA_W - LO_W;
	localparam int ACC_W  = PROD_W + FRAC_W + 2;

	// Command queue between front and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int REG_IDX_W  = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_COEFFICIENT = '0;

	typedef enum logic [1:0] {
		OP_SAMPLE     = 2'd0,
		OP_SAVE_START = 2'd1,
		OP_SAVE_STOP  = 2'd2,
		OP_CLEAR      = 2'd3
	} opcode_t;

	// Decoded command as it sits in the queue
	typedef struct packed {
		logic                sample_op;
		logic                save_start;
		logic                save_stop;
		logic                clear;
		logic [SAMPLE_W-1:0] sample;
	} cmd_t;

	// Head of the queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

/* hw/rtl/gsbp_item_if.sv */
// ----------------------------------------------------------------------------
// gsbp_item_if
// Input channel: one operation with its sample per beat.
// ----------------------------------------------------------------------------
interface gsbp_item_if;
	logic                              valid;
	logic                              ready;
	gsbp_pkg::opcode_t                 opcode;
	logic [gsbp_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, output opcode, output sample, input ready);
	modport sink   (input valid, input opcode, input sample, output ready);
endinterface

/* hw/rtl/gsbp_result_if.sv */
// ----------------------------------------------------------------------------
// gsbp_result_if
// Output channel: current, start and stop power per beat.
// ----------------------------------------------------------------------------
interface gsbp_result_if;
	logic                          valid;
	logic                          ready;
	logic [gsbp_pkg::POWER_W-1:0]  power;
	logic [gsbp_pkg::POWER_W-1:0]  start_power;
	logic [gsbp_pkg::POWER_W-1:0]  stop_power;

	modport source (output valid, output power, output start_power, output stop_power,
		input ready);
	modport sink   (input valid, input power, input start_power, input stop_power,
		output ready);
endinterface

/* hw/rtl/gsbp_cfg.sv */
// ----------------------------------------------------------------------------
// gsbp_cfg
// APB register file holding the Goertzel coefficient.
// ----------------------------------------------------------------------------
module gsbp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gsbp_pkg::PADDR_W-1:0]    paddr,
	input  logic [gsbp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gsbp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [gsbp_pkg::COEF_W-1:0]     coef
);
	import gsbp_pkg::*;

	logic [COEF_W-1:0]    coef_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 hit;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign hit     = (reg_idx == REG_COEFFICIENT);
	assign pready  = 1'b1;
	assign coef    = coef_q;

	// Take the write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (psel && penable && pwrite && hit) begin
			coef_q <= pwdata[COEF_W-1:0];
		end
	end

	// Return the coefficient sign-extended, zero elsewhere
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(APB_DATA_W-COEF_W){coef_q[COEF_W-1]}}, coef_q};
		end
	end

endmodule

/* hw/rtl/gsbp_front.sv */
// ----------------------------------------------------------------------------
// gsbp_front
// Accepts input beats, decodes the opcode and queues the command.
// ----------------------------------------------------------------------------
module gsbp_front (
	input  logic            clk,
	input  logic            arst_n,
	gsbp_item_if.sink       req,
	output gsbp_pkg::head_t head,
	input  logic            pop
);
	import gsbp_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              dec;
	logic              push;

	// Decode the opcode into one-hot command flags
	always_comb begin
		dec        = '0;
		dec.sample = req.sample;
		case (req.opcode)
			OP_SAMPLE:     dec.sample_op  = 1'b1;
			OP_SAVE_START: dec.save_start = 1'b1;
			OP_SAVE_STOP:  dec.save_stop  = 1'b1;
			OP_CLEAR:      dec.clear      = 1'b1;
			default:       dec.clear      = 1'b1;
		endcase
	end

	assign req.ready  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = req.valid && req.ready;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// Store the decoded command
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* hw/rtl/gsbp_back.sv */
// ----------------------------------------------------------------------------
// gsbp_back
// Executes queued commands: tap recurrence and bin power through one
// shared multiplier, power latches, and the output register.
// ----------------------------------------------------------------------------
module gsbp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gsbp_pkg::COEF_W-1:0] coef,
	input  gsbp_pkg::head_t             head,
	output logic                        pop,
	gsbp_result_if.source               rsp
);
	import gsbp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_C0   = 3'd1;
	localparam logic [2:0] ST_C1   = 3'd2;
	localparam logic [2:0] ST_C2   = 3'd3;
	localparam logic [2:0] ST_C3   = 3'd4;
	localparam logic [2:0] ST_C4   = 3'd5;
	localparam logic [2:0] ST_C5   = 3'd6;

	localparam int MW     = CA_W + 1 - FRAC_W;
	localparam int TSUM_W = MW + 2;
	localparam int PSGN_W = ACC_W - FRAC_W - POWER_W + 1;

	logic [2:0]             state_q;
	logic [TAP_WIDTH-1:0]   tap_now_q, tap_one_q, tap_two_q;
	logic [POWER_W-1:0]     power_q, start_q, stop_q;
	logic [SAMPLE_W-1:0]    x_q;
	logic [CA_W-1:0]        ca_q;
	logic [ACC_W-1:0]       acc_q;
	logic [PROD_W-1:0]      p_q;
	logic                   rsp_valid_q;
	logic [POWER_W-1:0]     rsp_power_q, rsp_start_q, rsp_stop_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [CA_W-1:0]          ca;
	logic [CA_W:0]            m_sum;
	logic [MW-1:0]            m;
	logic [TSUM_W-1:0]        t_sum;
	logic                     t_ovf;
	logic [TAP_WIDTH-1:0]     tap_sat;
	logic [ACC_W-1:0]         fin;
	logic                     pw_ovf;
	logic [POWER_W-1:0]       pw_sat;
	logic                     slot_free;
	logic                     done;
	logic [POWER_W-1:0]       power_nx, start_nx, stop_nx;

	// Select multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_C0: begin
				mul_a = {{(MUL_W-COEF_W){coef[COEF_W-1]}}, coef};
				mul_b = {{(MUL_W-TAP_WIDTH){tap_now_q[TAP_WIDTH-1]}}, tap_now_q};
			end
			ST_C1: begin
				mul_a = {{(MUL_W-TAP_WIDTH){tap_one_q[TAP_WIDTH-1]}}, tap_one_q};
				mul_b = mul_a;
			end
			ST_C2: begin
				mul_a = {{(MUL_W-TAP_WIDTH){tap_two_q[TAP_WIDTH-1]}}, tap_two_q};
				mul_b = mul_a;
			end
			ST_C3: begin
				mul_a = {{(MUL_W-LO_W){1'b0}}, ca_q[LO_W-1:0]};
				mul_b = {{(MUL_W-TAP_WIDTH){tap_two_q[TAP_WIDTH-1]}}, tap_two_q};
			end
			ST_C4: begin
				mul_a = {{(MUL_W-HI_W){ca_q[CA_W-1]}}, ca_q[CA_W-1:LO_W]};
				mul_b = {{(MUL_W-TAP_WIDTH){tap_two_q[TAP_WIDTH-1]}}, tap_two_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// New tap: round c*tap_one half up, subtract tap_two, add sample, saturate
	assign ca    = p_q[CA_W-1:0];
	assign m_sum = {ca[CA_W-1], ca} + (CA_W+1)'(ROUND_HALF);
	assign m     = m_sum[CA_W:FRAC_W];
	assign t_sum = {{(TSUM_W-MW){m[MW-1]}}, m}
		- {{(TSUM_W-TAP_WIDTH){tap_two_q[TAP_WIDTH-1]}}, tap_two_q}
		+ {{(TSUM_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
	assign t_ovf = (t_sum[TSUM_W-1:TAP_WIDTH-1]
		!= {(TSUM_W-TAP_WIDTH+1){t_sum[TSUM_W-1]}});
	assign tap_sat = !t_ovf ? t_sum[TAP_WIDTH-1:0]
		: (t_sum[TSUM_W-1] ? {1'b1, {(TAP_WIDTH-1){1'b0}}} : {1'b0, {(TAP_WIDTH-1){1'b1}}});

	// Last partial product closes the power sum; shift and saturate
	assign fin    = acc_q - {p_q[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
	assign pw_ovf = (fin[ACC_W-1:FRAC_W+POWER_W-1] != {PSGN_W{fin[ACC_W-1]}});
	assign pw_sat = !pw_ovf ? fin[FRAC_W+POWER_W-1:FRAC_W]
		: (fin[ACC_W-1] ? {1'b1, {(POWER_W-1){1'b0}}} : {1'b0, {(POWER_W-1){1'b1}}});

	assign slot_free = !rsp_valid_q || rsp.ready;

	// Dequeue and finish decisions
	always_comb begin
		pop      = 1'b0;
		done     = 1'b0;
		power_nx = power_q;
		start_nx = start_q;
		stop_nx  = stop_q;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					if (head.cmd.sample_op) begin
						pop = 1'b1;
					end else if (slot_free) begin
						pop  = 1'b1;
						done = 1'b1;
						if (head.cmd.save_start) start_nx = power_q;
						if (head.cmd.save_stop)  stop_nx  = power_q;
						if (head.cmd.clear)      power_nx = '0;
					end
				end
			end
			ST_C5: begin
				if (slot_free) begin
					done     = 1'b1;
					power_nx = pw_sat;
				end
			end
			default: begin
				pop  = 1'b0;
				done = 1'b0;
			end
		endcase
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tap_now_q <= '0;
			tap_one_q <= '0;
			tap_two_q <= '0;
			power_q   <= '0;
			start_q   <= '0;
			stop_q    <= '0;
		end else begin
			if (done) begin
				power_q <= power_nx;
				start_q <= start_nx;
				stop_q  <= stop_nx;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head.cmd.sample_op) begin
						state_q <= ST_C0;
					end
					if (pop && head.cmd.clear) begin
						tap_now_q <= '0;
						tap_one_q <= '0;
						tap_two_q <= '0;
					end
				end
				ST_C0: begin
					tap_two_q <= tap_one_q;
					tap_one_q <= tap_now_q;
					state_q   <= ST_C1;
				end
				ST_C1: begin
					tap_now_q <= tap_sat;
					state_q   <= ST_C2;
				end
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_C4;
				ST_C4: state_q <= ST_C5;
				ST_C5: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: product, c*tap_one, power accumulator, sample
	always_ff @(posedge clk) begin
		if (state_q != ST_C5) begin
			p_q <= prod;
		end
		if (pop) begin
			x_q <= head.cmd.sample;
		end
		case (state_q)
			ST_C1: ca_q <= ca;
			ST_C2: acc_q <= {{(ACC_W-PROD_W-FRAC_W){p_q[PROD_W-1]}}, p_q, {FRAC_W{1'b0}}}
				+ ACC_W'(ROUND_HALF);
			ST_C3: acc_q <= acc_q
				+ {{(ACC_W-PROD_W-FRAC_W){p_q[PROD_W-1]}}, p_q, {FRAC_W{1'b0}}};
			ST_C4: acc_q <= acc_q - {{(ACC_W-PROD_W){p_q[PROD_W-1]}}, p_q};
			default: acc_q <= acc_q;
		endcase
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_power_q <= power_nx;
			rsp_start_q <= start_nx;
			rsp_stop_q  <= stop_nx;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.power       = rsp_power_q;
	assign rsp.start_power = rsp_start_q;
	assign rsp.stop_power  = rsp_stop_q;

endmodule

/* hw/rtl/goertzel_single_bin_power_top.sv */
// ----------------------------------------------------------------------------
// goertzel_single_bin_power_top
// Single-bin Goertzel power detector with APB coefficient register.
// ----------------------------------------------------------------------------
// Each input beat is one operation and yields exactly one output beat with the
// current, start and stop power. A sample is dequeued, then five products go
// through a single shared 33x33 multiplier (c*tap, tap_one^2, tap_two^2 and two
// partial products of c*tap_one*tap_two), then the final round and saturate.
// Save-start, save-stop and clear complete in the same cycle as they are dequeued.
// A two-entry command queue sits in front of the back end, so input beats are
// taken while a sample is in flight or a result waits on the output register.
// The coefficient is written over APB at byte address 0.
module goertzel_single_bin_power_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gsbp_pkg::PADDR_W-1:0]    paddr,
	input  logic [gsbp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [gsbp_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	gsbp_item_if.sink                       req,
	gsbp_result_if.source                   rsp
);
	import gsbp_pkg::*;

	logic [COEF_W-1:0] coef;
	head_t             head;
	logic              pop;

	gsbp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	gsbp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.head   (head),
		.pop    (pop)
	);

	gsbp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

/* hw/rtl/gsbp_checker.sv */
// ----------------------------------------------------------------------------
// gsbp_checker
// Port-level checks of the Goertzel detector, bound to the top level.
// ----------------------------------------------------------------------------
module gsbp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pready,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [gsbp_pkg::POWER_W-1:0] power
);
	import gsbp_pkg::*;

	localparam int CAP    = QUEUE_DEPTH + 2;
	localparam int OUTS_W = $clog2(CAP + 1);

	logic [OUTS_W-1:0] outst_q;
	logic              in_beat, out_beat;

	assign in_beat  = req_valid && req_ready;
	assign out_beat = rsp_valid && rsp_ready;

	// Track beats taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			case ({in_beat, out_beat})
				2'b10:   outst_q <= outst_q + 1'b1;
				2'b01:   outst_q <= outst_q - 1'b1;
				default: outst_q <= outst_q;
			endcase
		end
	end

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (outst_q != '0))
		else $error("result beat without an outstanding item");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= OUTS_W'(CAP))
		else $error("more items in flight than the block can hold");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(outst_q == OUTS_W'(CAP)) |-> !req_ready)
		else $error("input taken while queue, engine and output are full");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(power))
		else $error("stalled result changed");

endmodule

bind goertzel_single_bin_power_top gsbp_checker u_gsbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.power     (rsp.power)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-bin Goertzel power detector.
// ----------------------------------------------------------------------------
// Feeds operations on the item channel, programs the coefficient over APB,
// and checks every result beat against an in-bench fixed-point predictor of
// the tap recurrence, the bin power and the start/stop latches. Both channels
// idle at random; the long saturation run and one phase run with no idling,
// and one phase pauses the sender until every outstanding result has drained.
module tb_top;
	import gsbp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int PRINT_LIMIT    = 40;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

	typedef struct {
		opcode_t     op;
		logic [15:0] smp;
	} beat_t;

	typedef struct packed {
		logic [POWER_W-1:0] power;
		logic [POWER_W-1:0] start_power;
		logic [POWER_W-1:0] stop_power;
	} bin_powers_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	gsbp_item_if   req_if ();
	gsbp_result_if rsp_if ();

	goertzel_single_bin_power_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if.sink),
		.rsp     (rsp_if.source)
	);

	// Predictor state: coefficient copy, taps and latched powers
	logic signed [COEF_W-1:0]    coef_shadow;
	logic signed [TAP_WIDTH-1:0] tap_new, tap_d1, tap_d2;
	logic        [POWER_W-1:0]   pwr_now, pwr_start, pwr_stop;

	beat_t       op_q[$];
	bin_powers_t powers_q[$];
	beat_t       next_beat;

	int unsigned req_idle_pct = 30;
	int unsigned rsp_idle_pct = 30;
	logic        hold_send    = 1'b0;
	int          mismatches   = 0;
	int          results_seen = 0;
	int          stall_cycles = 0;

	always #5 clk = ~clk;

	// Advance the Goertzel state by one operation and return the three powers
	function automatic bin_powers_t goertzel_step(opcode_t op, logic signed [15:0] x);
		logic signed [127:0] cc, w1, w2, acc;
		bin_powers_t         res;
		cc = coef_shadow;
		case (op)
			OP_SAMPLE: begin
				tap_d2 = tap_d1;
				tap_d1 = tap_new;
				w1 = tap_d1;
				w2 = tap_d2;
				// round c*tap half up, then add the new sample and clamp
				acc = ((cc * w1 + 8192) >>> FRAC_W) - w2 + x;
				if (acc > ((128'sd1 <<< (TAP_WIDTH - 1)) - 1))
					tap_new = {1'b0, {(TAP_WIDTH-1){1'b1}}};
				else if (acc < -(128'sd1 <<< (TAP_WIDTH - 1)))
					tap_new = {1'b1, {(TAP_WIDTH-1){1'b0}}};
				else
					tap_new = acc[TAP_WIDTH-1:0];
				// power from the delayed taps, exact, then round and clamp to 64 bits
				acc = (((w1 * w1 + w2 * w2) <<< FRAC_W) - cc * w1 * w2 + 8192) >>> FRAC_W;
				if (acc[127:63] == {65{acc[127]}})
					pwr_now = acc[63:0];
				else
					pwr_now = acc[127] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
			end
			OP_SAVE_START: pwr_start = pwr_now;
			OP_SAVE_STOP:  pwr_stop  = pwr_now;
			default: begin
				tap_new = '0;
				tap_d1  = '0;
				tap_d2  = '0;
				pwr_now = '0;
			end
		endcase
		res.power       = pwr_now;
		res.start_power = pwr_start;
		res.stop_power  = pwr_stop;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch %s at result %0d: got %h want %h", what, results_seen, got, want);
	endtask

	// Item driver: launch the next pending beat, predict on every accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid  <= 1'b0;
			req_if.opcode <= OP_SAMPLE;
			req_if.sample <= '0;
		end else begin
			if (req_if.valid && req_if.ready)
				powers_q.push_back(goertzel_step(req_if.opcode, req_if.sample));
			if (!req_if.valid || req_if.ready) begin
				if (op_q.size() != 0 && !hold_send && $urandom_range(99) >= req_idle_pct) begin
					next_beat = op_q.pop_front();
					req_if.valid  <= 1'b1;
					req_if.opcode <= next_beat.op;
					req_if.sample <= next_beat.smp;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each beat with the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (powers_q.size() == 0) begin
					report_mismatch("unexpected beat", rsp_if.power, '0);
				end else begin
					bin_powers_t want;
					want = powers_q.pop_front();
					if (rsp_if.power !== want.power)
						report_mismatch("power", rsp_if.power, want.power);
					if (rsp_if.start_power !== want.start_power)
						report_mismatch("start_power", rsp_if.start_power, want.start_power);
					if (rsp_if.stop_power !== want.stop_power)
						report_mismatch("stop_power", rsp_if.stop_power, want.stop_power);
				end
				results_seen++;
			end
			rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// Watchdog: end the run after too many cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", stall_cycles);
				$display("FAILURE");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic push_op(input opcode_t op, input logic [15:0] smp);
		beat_t b;
		b.op  = op;
		b.smp = smp;
		op_q.push_back(b);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(3))
			0:       return 16'($urandom_range(64)) - 16'd32;
			1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Queue one well-formed measurement window or a short run of noise
	task automatic queue_burst(inout int added);
		int n;
		if ($urandom_range(9) < 7) begin
			n = $urandom_range(16, 1);
			if ($urandom_range(1)) begin
				push_op(OP_CLEAR, 16'($urandom));
				added++;
			end
			push_op(OP_SAVE_START, 16'($urandom));
			repeat (n) push_op(OP_SAMPLE, pick_sample());
			push_op(OP_SAVE_STOP, 16'($urandom));
			added += n + 2;
		end else begin
			n = $urandom_range(4, 1);
			repeat (n) push_op(opcode_t'($urandom_range(3)), 16'($urandom));
			added += n;
		end
	endtask

	// Hold until nothing is pending, in flight or outstanding
	task automatic wait_quiet();
		while (op_q.size() != 0 || req_if.valid || powers_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Program the coefficient once the block is idle; poke the spare address and read back
	task automatic set_coefficient(input logic [15:0] c);
		logic [APB_DATA_W-1:0] rd;
		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_access(1'b1, {REG_COEFFICIENT, 2'b00}, {16'($urandom), c}, rd);
		coef_shadow = c;
		apb_access(1'b1, {REG_SPARE, 2'b00}, $urandom, rd);
		apb_access(1'b0, {REG_COEFFICIENT, 2'b00}, '0, rd);
		if (rd[15:0] !== c)
			report_mismatch("coefficient readback", 64'(rd[15:0]), 64'(c));
	endtask

	initial begin
		logic [15:0] phase_coef[7];
		int          added;

		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_if.valid   = 1'b0;
		req_if.opcode  = OP_SAMPLE;
		req_if.sample  = '0;
		rsp_if.ready   = 1'b0;
		coef_shadow    = '0;
		tap_new        = '0;
		tap_d1         = '0;
		tap_d2         = '0;
		pwr_now        = '0;
		pwr_start      = '0;
		pwr_stop       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset coefficient, field extremes, ignored sample on other ops
		push_op(OP_SAVE_START, 16'hffff);
		push_op(OP_SAMPLE, 16'h7fff);
		push_op(OP_SAMPLE, 16'h8000);
		push_op(OP_SAMPLE, 16'hffff);
		push_op(OP_SAVE_START, 16'h7fff);
		push_op(OP_SAMPLE, 16'h0001);
		push_op(OP_SAVE_STOP, 16'h8000);
		push_op(OP_CLEAR, 16'h7fff);
		push_op(OP_SAVE_STOP, 16'h0000);
		push_op(OP_SAMPLE, 16'h0000);

		// Directed: largest coefficient exercises the half-up rounding of c*tap
		set_coefficient(16'h7fff);
		repeat (4) push_op(OP_SAMPLE, 16'h7fff);
		push_op(OP_SAMPLE, 16'h8000);
		push_op(OP_SAMPLE, 16'd12345);
		push_op(OP_SAVE_START, 16'h5555);
		push_op(OP_CLEAR, 16'haaaa);
		push_op(OP_SAMPLE, 16'h8000);
		push_op(OP_SAMPLE, 16'h0001);
		push_op(OP_SAVE_STOP, 16'h1234);

		// Drive the taps into saturation: Nyquist resonance with alternating full scale.
		// The taps clip after about 360 samples; run this stretch with no idling.
		set_coefficient(16'h8000);
		req_idle_pct <= 0;
		rsp_idle_pct <= 0;
		push_op(OP_CLEAR, 16'h0000);
		push_op(OP_SAVE_START, 16'h0000);
		for (int i = 0; i < 372; i++)
			push_op(OP_SAMPLE, (i % 2) ? 16'h8000 : 16'h7fff);
		push_op(OP_SAVE_STOP, 16'h0000);
		push_op(OP_CLEAR, 16'h0000);

		// Random phases, each under its own coefficient
		phase_coef = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000,
			16'($urandom), 16'($urandom), 16'hc000};
		for (int p = 0; p < 7; p++) begin
			set_coefficient(phase_coef[p]);
			req_idle_pct <= (p == 3) ? 0 : 30;
			rsp_idle_pct <= (p == 3) ? 0 : 30;
			added = 0;
			while (added < 8)
				queue_burst(added);
			// hold the sender mid-phase until every outstanding result is back
			if (p == 1) begin
				while (op_q.size() > 4)
					@(posedge clk);
				hold_send <= 1'b1;
				do @(posedge clk); while (req_if.valid || powers_q.size() != 0);
				hold_send <= 1'b0;
			end
		end

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
